[design/bdll_pkg.sv]
package bdll_pkg;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] target_key;
      logic signed [31:0] new_value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] result_value;
      logic [8:0]         entry_count;
   } rsp_type;

   localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
   localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
   localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
   localparam logic [3:0] MODE_POP_BACK   = 4'd3;
   localparam logic [3:0] MODE_FIND       = 4'd4;
   localparam logic [3:0] MODE_INS_BEFORE = 4'd5;
   localparam logic [3:0] MODE_INS_AFTER  = 4'd6;
   localparam logic [3:0] MODE_DEL_KEY    = 4'd7;
   localparam logic [3:0] MODE_PEEK_IDX   = 4'd8;
   localparam logic [3:0] MODE_DEL_IDX    = 4'd9;
   localparam logic [3:0] MODE_FRONT      = 4'd10;
   localparam logic [3:0] MODE_BACK       = 4'd11;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

[design/bounded_doubly_linked_list_engine.sv]
// Items answered at once (errors, unused modes) go straight to S_DONE; front, back and
// one-entry peek pass S_READ; push passes S_FREE, S_LINK and S_LINK2; pop passes S_UNLINK,
// S_FOUND and S_UNL2. Searches and index walks pass S_WALK and S_FOUND once per link,
// up to CAPACITY links. One item at a time; a new item is taken only back in S_IDLE,
// after its result loads, and S_DONE waits while rsp_stall holds the previous result.
// Reset: empty list, free stack pointer at CAPACITY, then S_INIT loads each free stack
// entry with its own index while req_stall stays high.
module bounded_doubly_linked_list_engine #(
   parameter int CAPACITY = 256,
   parameter int KEY_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bdll_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bdll_pkg::rsp_type  rsp_data
);
   import bdll_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] NIL = CW'(CAPACITY);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_FOUND  = 4'd3;
   localparam logic [3:0] S_FREE   = 4'd4;
   localparam logic [3:0] S_LINK   = 4'd5;
   localparam logic [3:0] S_LINK2  = 4'd6;
   localparam logic [3:0] S_UNLINK = 4'd7;
   localparam logic [3:0] S_UNL2   = 4'd8;
   localparam logic [3:0] S_READ   = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   // node memory: key, prev, next
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [CW-1:0]       prev_mem [CAPACITY];
   logic [CW-1:0]       next_mem [CAPACITY];
   logic [AW-1:0]       free_mem [CAPACITY];

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in, ftop_ff, ftop_in;
   logic [CW-1:0]       init_ff, init_in;
   req_type             op_ff, op_in;
   logic [KEY_BITS-1:0] tkey_ff, tkey_in, nkey_ff, nkey_in;
   logic [CW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [CW-1:0]       lp_ff, lp_in, ln_ff, ln_in;
   logic [AW-1:0]       news_ff, news_in;
   logic [2:0]          st_ff, st_in;
   logic                vnone_ff, vnone_in;
   logic                rv_ff, rv_in;
   rsp_type             rsp_ff, rsp_in;

   // read port
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [KEY_BITS-1:0] rd_key;
   logic [CW-1:0]       rd_prev, rd_next;
   logic [AW-1:0]       fs_raddr, fs_rd;
   // write ports
   logic                wk_en, wp_en, wn_en, fs_wen;
   logic [AW-1:0]       wk_addr, wp_addr, wn_addr, fs_waddr, fs_wdata;
   logic [KEY_BITS-1:0] wk_data;
   logic [CW-1:0]       wp_data, wn_data;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key  <= key_mem[rd_addr];
         rd_prev <= prev_mem[rd_addr];
         rd_next <= next_mem[rd_addr];
      end
      fs_rd <= free_mem[fs_raddr];
      if (wk_en) key_mem[wk_addr] <= wk_data;
      if (wp_en) prev_mem[wp_addr] <= wp_data;
      if (wn_en) next_mem[wn_addr] <= wn_data;
      if (fs_wen) free_mem[fs_waddr] <= fs_wdata;
   end

   logic empty, full, accept, walk_hit, idx_op;
   assign empty  = (count_ff == '0) || (head_ff >= NIL);
   assign full   = count_ff >= CAP;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign idx_op = (op_ff.mode == MODE_PEEK_IDX) || (op_ff.mode == MODE_DEL_IDX);
   assign walk_hit = (op_ff.mode == MODE_POP_FRONT || op_ff.mode == MODE_POP_BACK) ? 1'b1 :
                     idx_op ? (steps_ff == CW'(op_ff.position)) : (rd_key == tkey_ff);

   always_comb begin
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff;
      count_in = count_ff; ftop_in = ftop_ff; init_in = init_ff;
      op_in = op_ff; tkey_in = tkey_ff; nkey_in = nkey_ff;
      cur_in = cur_ff; steps_in = steps_ff; lp_in = lp_ff; ln_in = ln_ff;
      news_in = news_ff; st_in = st_ff; vnone_in = vnone_ff;
      rv_in = rv_ff; rsp_in = rsp_ff;
      rd_en = 1'b0; rd_addr = cur_ff[AW-1:0];
      fs_raddr = AW'(ftop_ff - 1'b1);
      wk_en = 1'b0; wk_addr = news_ff; wk_data = nkey_ff;
      wp_en = 1'b0; wp_addr = news_ff; wp_data = lp_ff;
      wn_en = 1'b0; wn_addr = news_ff; wn_data = ln_ff;
      fs_wen = 1'b0; fs_waddr = init_ff[AW-1:0]; fs_wdata = init_ff[AW-1:0];

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      case (state_ff)
         S_INIT: begin
            fs_wen = 1'b1;
            init_in = init_ff + 1'b1;
            if (init_ff == CAP - 1'b1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               op_in = req_data;
               tkey_in = KEY_BITS'(req_data.target_key);
               nkey_in = KEY_BITS'(req_data.new_value);
               st_in = ST_OK; vnone_in = 1'b1;
               cur_in = head_ff; steps_in = '0;
               state_in = S_DONE;
               case (req_data.mode)
                  MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                     if (full) st_in = ST_FULL;
                     else begin
                        lp_in = (req_data.mode == MODE_PUSH_FRONT) ? NIL : tail_ff;
                        ln_in = (req_data.mode == MODE_PUSH_FRONT) ? head_ff : NIL;
                        state_in = S_FREE;
                     end
                  end
                  MODE_POP_FRONT, MODE_POP_BACK: begin
                     if (empty) st_in = ST_EMPTY;
                     else begin
                        cur_in = (req_data.mode == MODE_POP_FRONT) ? head_ff : tail_ff;
                        state_in = S_UNLINK;
                     end
                  end
                  MODE_FIND: state_in = S_WALK;
                  MODE_INS_BEFORE, MODE_INS_AFTER: begin
                     if (full) st_in = ST_FULL;
                     else if (count_ff <= CW'(1)) begin
                        lp_in = (req_data.mode == MODE_INS_BEFORE) ? NIL : tail_ff;
                        ln_in = (req_data.mode == MODE_INS_BEFORE) ? head_ff : NIL;
                        state_in = S_FREE;
                     end else state_in = S_WALK;
                  end
                  MODE_DEL_KEY: begin
                     if (empty) st_in = ST_EMPTY;
                     else state_in = S_WALK;
                  end
                  MODE_PEEK_IDX: begin
                     if (empty) st_in = ST_EMPTY;
                     else if (count_ff == CW'(1)) state_in = S_READ;
                     else if (32'(req_data.position) >= 32'(count_ff)) st_in = ST_RANGE;
                     else state_in = S_WALK;
                  end
                  MODE_DEL_IDX: begin
                     if (empty) st_in = ST_EMPTY;
                     else if (32'(req_data.position) >= 32'(count_ff)) st_in = ST_RANGE;
                     else state_in = S_WALK;
                  end
                  MODE_FRONT, MODE_BACK: begin
                     if (empty) st_in = ST_EMPTY;
                     else begin
                        cur_in = (req_data.mode == MODE_FRONT) ? head_ff : tail_ff;
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            // issue read of cur; result examined in S_FOUND
            if (cur_ff >= NIL || steps_ff >= CAP) begin
               st_in = idx_op ? ST_RANGE : ST_NOTFOUND;
               state_in = S_DONE;
            end else begin
               rd_en = 1'b1;
               state_in = S_FOUND;
            end
         end
         S_FOUND: begin
            if (walk_hit) begin
               case (op_ff.mode)
                  MODE_FIND, MODE_PEEK_IDX: begin
                     vnone_in = 1'b0; state_in = S_DONE;
                  end
                  MODE_INS_BEFORE: begin
                     lp_in = rd_prev; ln_in = cur_ff; state_in = S_FREE;
                  end
                  MODE_INS_AFTER: begin
                     lp_in = cur_ff; ln_in = rd_next; state_in = S_FREE;
                  end
                  default: begin
                     lp_in = rd_prev; ln_in = rd_next; state_in = S_UNL2;
                  end
               endcase
            end else begin
               cur_in = rd_next;
               steps_in = steps_ff + 1'b1;
               state_in = S_WALK;
            end
         end
         S_FREE: begin
            // fs_rd valid next cycle
            state_in = S_LINK;
         end
         S_LINK: begin
            // neighbors point at the new slot
            news_in = fs_rd;
            ftop_in = ftop_ff - 1'b1;
            if (lp_ff < NIL) begin
               wn_en = 1'b1; wn_addr = lp_ff[AW-1:0]; wn_data = CW'(fs_rd);
            end
            if (ln_ff < NIL) begin
               wp_en = 1'b1; wp_addr = ln_ff[AW-1:0]; wp_data = CW'(fs_rd);
            end
            state_in = S_LINK2;
         end
         S_LINK2: begin
            wk_en = 1'b1; wp_en = 1'b1; wn_en = 1'b1;
            if (lp_ff >= NIL) head_in = CW'(news_ff);
            if (ln_ff >= NIL) tail_in = CW'(news_ff);
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end
         S_UNLINK: begin
            rd_en = 1'b1;
            state_in = S_FOUND;
         end
         S_UNL2: begin
            if (lp_ff < NIL) begin
               wn_en = 1'b1; wn_addr = lp_ff[AW-1:0]; wn_data = ln_ff;
            end else head_in = ln_ff;
            if (ln_ff < NIL) begin
               wp_en = 1'b1; wp_addr = ln_ff[AW-1:0]; wp_data = lp_ff;
            end else tail_in = lp_ff;
            fs_wen = 1'b1; fs_waddr = ftop_ff[AW-1:0]; fs_wdata = cur_ff[AW-1:0];
            ftop_in = ftop_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = S_DONE;
         end
         S_READ: begin
            rd_en = 1'b1;
            state_in = S_DONE;
            vnone_in = 1'b0;
         end
         S_DONE: begin
            // wait while the previous result is still held
            if (!rv_ff || !rsp_stall) begin
               rsp_in.status = st_ff;
               rsp_in.entry_count = 9'(count_ff);
               rsp_in.result_value = vnone_ff ? -32'sd1 : 32'(signed'(rd_key));
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff  <= NIL;
         tail_ff  <= NIL;
         count_ff <= '0;
         ftop_ff  <= CAP;
         init_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         ftop_ff  <= ftop_in;
         init_ff  <= init_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; tkey_ff <= tkey_in; nkey_ff <= nkey_in;
      cur_ff <= cur_in; steps_ff <= steps_in; lp_ff <= lp_in; ln_ff <= ln_in;
      news_ff <= news_in; st_ff <= st_in; vnone_ff <= vnone_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule

[verif/bounded_doubly_linked_list_engine_tb.sv]
module bounded_doubly_linked_list_engine_tb;
   import bdll_pkg::*;

   localparam int CAP = 256;
   localparam logic [8:0] NULL_SLOT = 9'd256;

   class list_scoreboard;
      logic signed [31:0] keys [CAP];
      logic [8:0] nxt [CAP];
      logic [8:0] prv [CAP];
      logic [8:0] head, tail, count;
      logic [7:0] free_slots [CAP];
      int unsigned free_top;
      rsp_type pending [$];
      int errors;

      function new();
         for (int i = 0; i < CAP; i++) begin
            keys[i] = 0;
            nxt[i] = 0;
            prv[i] = 0;
            free_slots[i] = i[7:0];
         end
         head = NULL_SLOT;
         tail = NULL_SLOT;
         count = 0;
         free_top = CAP;
         errors = 0;
      endfunction

      function logic [8:0] find_key(logic signed [31:0] k);
         logic [8:0] s;
         s = head;
         for (int i = 0; i < CAP && s < NULL_SLOT; i++) begin
            if (keys[s[7:0]] == k) return s;
            s = nxt[s[7:0]];
         end
         return NULL_SLOT;
      endfunction

      function logic [8:0] walk_to(logic [7:0] p);
         logic [8:0] s;
         s = head;
         for (int i = 0; i < p && s < NULL_SLOT; i++) s = nxt[s[7:0]];
         return s;
      endfunction

      function void link_in(logic [8:0] p, logic [8:0] n, logic signed [31:0] k);
         logic [7:0] s;
         free_top--;
         s = free_slots[free_top];
         keys[s] = k;
         prv[s] = p;
         nxt[s] = n;
         if (p < NULL_SLOT) nxt[p[7:0]] = {1'b0, s}; else head = {1'b0, s};
         if (n < NULL_SLOT) prv[n[7:0]] = {1'b0, s}; else tail = {1'b0, s};
         count++;
      endfunction

      function void unlink(logic [8:0] s);
         logic [8:0] p, n;
         p = prv[s[7:0]];
         n = nxt[s[7:0]];
         if (p < NULL_SLOT) nxt[p[7:0]] = n; else head = n;
         if (n < NULL_SLOT) prv[n[7:0]] = p; else tail = p;
         free_slots[free_top] = s[7:0];
         free_top++;
         count--;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic [8:0] s;
         logic empty, full;
         e.status = ST_OK;
         e.result_value = -1;
         empty = (count == 0);
         full = (count >= CAP);
         case (r.mode)
            MODE_PUSH_FRONT: if (full) e.status = ST_FULL;
                             else link_in(NULL_SLOT, head, r.new_value);
            MODE_PUSH_BACK:  if (full) e.status = ST_FULL;
                             else link_in(tail, NULL_SLOT, r.new_value);
            MODE_POP_FRONT:  if (empty) e.status = ST_EMPTY; else unlink(head);
            MODE_POP_BACK:   if (empty) e.status = ST_EMPTY; else unlink(tail);
            MODE_FIND: begin
               s = find_key(r.target_key);
               if (s < NULL_SLOT) e.result_value = keys[s[7:0]];
               else e.status = ST_NOTFOUND;
            end
            MODE_INS_BEFORE, MODE_INS_AFTER: begin
               if (full) e.status = ST_FULL;
               else if (count <= 1) begin
                  if (r.mode == MODE_INS_BEFORE) link_in(NULL_SLOT, head, r.new_value);
                  else link_in(tail, NULL_SLOT, r.new_value);
               end else begin
                  s = find_key(r.target_key);
                  if (s >= NULL_SLOT) e.status = ST_NOTFOUND;
                  else if (r.mode == MODE_INS_BEFORE) link_in(prv[s[7:0]], s, r.new_value);
                  else link_in(s, nxt[s[7:0]], r.new_value);
               end
            end
            MODE_DEL_KEY: begin
               if (empty) e.status = ST_EMPTY;
               else begin
                  s = find_key(r.target_key);
                  if (s < NULL_SLOT) unlink(s); else e.status = ST_NOTFOUND;
               end
            end
            MODE_PEEK_IDX: begin
               if (empty) e.status = ST_EMPTY;
               else if (count == 1) e.result_value = keys[head[7:0]];
               else if (r.position >= count) e.status = ST_RANGE;
               else begin
                  s = walk_to(r.position);
                  e.result_value = keys[s[7:0]];
               end
            end
            MODE_DEL_IDX: begin
               if (empty) e.status = ST_EMPTY;
               else if (r.position >= count) e.status = ST_RANGE;
               else unlink(walk_to(r.position));
            end
            MODE_FRONT:      if (empty) e.status = ST_EMPTY;
                             else e.result_value = keys[head[7:0]];
            MODE_BACK:       if (empty) e.status = ST_EMPTY;
                             else e.result_value = keys[tail[7:0]];
            default: ;
         endcase
         e.entry_count = count;
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.result_value !== e.result_value) begin
            $display("%0t: value expected %0d got %0d", $time,
                     e.result_value, a.result_value);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: count expected %0d got %0d", $time,
                     e.entry_count, a.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;

   list_scoreboard board;
   int hold_cycles;
   logic calm;
   logic [31:0] recent_keys [8];

   bounded_doubly_linked_list_engine uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
   end

   // receiver: random stall bursts, or a long hold when asked
   initial begin
      rsp_stall = 0;
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            @(posedge clock);
         end
      end
   end

   task automatic send(logic [3:0] m, logic [31:0] tk, logic [31:0] nv, logic [7:0] p);
      req_type r;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      r.mode = m;
      r.target_key = tk;
      r.new_value = nv;
      r.position = p;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      recent_keys[$urandom_range(0, 7)] = nv;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 15);
         default: return recent_keys[$urandom_range(0, 7)];
      endcase
   endfunction

   initial begin
      logic [3:0] m;
      board = new();
      hold_cycles = 0;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      for (int i = 0; i < 8; i++) recent_keys[i] = i;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty list cases
      for (int i = 0; i < 12; i++) send(i[3:0], 5, 7, 0);
      send(4'd12, 0, 0, 0);
      send(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      send(MODE_INS_AFTER, 99, 32'h7FFF_FFFF, 0);
      send(MODE_PEEK_IDX, 0, 0, 8'hFF);
      send(MODE_DEL_IDX, 0, 0, 1);
      send(MODE_INS_BEFORE, 99, 32'h8000_0000, 0);
      send(MODE_INS_BEFORE, 32'h7FFF_FFFF, 3, 0);
      send(MODE_INS_AFTER, 32'h8000_0000, 4, 0);
      send(MODE_INS_AFTER, 12345, 4, 0);
      send(MODE_PEEK_IDX, 0, 0, 3);
      send(MODE_DEL_IDX, 0, 0, 3);
      send(MODE_FIND, 32'h8000_0000, 0, 0);
      drain();

      // fill to full with a long receiver hold, then full cases
      hold_cycles = 3000;
      for (int i = 0; i < 260; i++) send(MODE_PUSH_BACK, 0, $urandom, 0);
      send(MODE_INS_BEFORE, 0, 1, 0);
      send(MODE_PEEK_IDX, 0, 0, 8'hFF);
      send(MODE_DEL_IDX, 0, 0, 8'hFF);
      drain();

      // random, drifting size
      for (int n = 0; n < 1150; n++) begin
         if (n == 1000) calm = 1;
         if (n % 300 == 150) drain();
         m = 4'($urandom_range(0, 15));
         if (m > 11 && $urandom_range(0, 3) != 0) m = 4'($urandom_range(0, 1));
         if (board.count < 40 && $urandom_range(0, 2) == 0) m = 4'($urandom_range(0, 1));
         send(m, pick_key(), ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 15)),
              8'(($urandom_range(0, 1) ? $urandom : $urandom_range(0, board.count))));
      end
      drain();
      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
